// ===== rtl/lsz_pkg.sv =====
package lsz_pkg;

    localparam int MAX_ASSETS   = 4;
    localparam int WINDOW_DEPTH = 64;
    localparam int PRICE_INPUTS = 4;
    localparam int ASSET_CAP    = (MAX_ASSETS < PRICE_INPUTS) ? MAX_ASSETS : PRICE_INPUTS;
    localparam int ASSET_W      = (PRICE_INPUTS > 1) ? $clog2(PRICE_INPUTS) : 1;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    localparam int PRICE_W    = 32;
    localparam int SPREAD_W   = 32;
    localparam int HEDGE_W    = 16;
    localparam int Z_W        = 16;
    localparam int ENTRIES_W  = 7;
    localparam int ASSETS_W   = 3;
    localparam int WINLEN_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LOG_FRAC = 20;
    localparam int LG_W     = 5 + LOG_FRAC;
    localparam int ACC_W    = 41;
    localparam int SUM_W    = SPREAD_W + ADDR_W + 1;

    localparam int MEAN_DIV_BITS = 40;
    localparam int VAR_DIV_BITS  = 64;
    localparam int Z_DIV_BITS    = 42;

    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [31:0] LN_TICK_Q16 = 32'd603609;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_UPD,
        ST_SCALE_MUL,
        ST_SCALE_FIN,
        ST_W_MUL,
        ST_W_ACC,
        ST_SPREAD,
        ST_PUSH,
        ST_SUM,
        ST_DIV,
        ST_VAR,
        ST_SQRT,
        ST_ZPREP,
        ST_FINISH
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ASSETS  = 3'd0,
        CFG_WINDOW  = 3'd1,
        CFG_HEDGE_A = 3'd2,
        CFG_HEDGE_B = 3'd3,
        CFG_HEDGE_C = 3'd4,
        CFG_HEDGE_D = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DOP_MEAN,
        DOP_VAR,
        DOP_Z
    } t_div_op;

endpackage

// ===== rtl/lsz_ifs.sv =====
interface lsz_in_if;
    logic                         valid;
    logic                         ready;
    logic [lsz_pkg::PRICE_W-1:0]  price_a;
    logic [lsz_pkg::PRICE_W-1:0]  price_b;
    logic [lsz_pkg::PRICE_W-1:0]  price_c;
    logic [lsz_pkg::PRICE_W-1:0]  price_d;

    modport source(output valid, price_a, price_b, price_c, price_d, input ready);
    modport sink(input valid, price_a, price_b, price_c, price_d, output ready);
endinterface

interface lsz_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lsz_pkg::SPREAD_W-1:0] spread_now;
    logic signed [lsz_pkg::SPREAD_W-1:0] spread_average;
    logic [lsz_pkg::SPREAD_W-1:0]        spread_deviation;
    logic signed [lsz_pkg::Z_W-1:0]      z_value;
    logic                                z_ok;
    logic [lsz_pkg::ENTRIES_W-1:0]       entries_held;

    modport source(output valid, spread_now, spread_average, spread_deviation, z_value, z_ok,
                   entries_held, input ready);
    modport sink(input valid, spread_now, spread_average, spread_deviation, z_value, z_ok,
                 entries_held, output ready);
endinterface

interface lsz_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lsz_pkg::CFG_IDX_W-1:0]   index;
    logic [lsz_pkg::CFG_DATA_W-1:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/log_spread_rolling_zscore.sv =====
// Throughput: one item at a time; the next input word is taken once the result is in the
//   output register. The shared 32x32 multiplier, the bit-serial divider and root unit set it.
// Reset: synchronous, active low; clears the sequencer, window pointers and fill, and loads
//   the default configuration. The spread store is not cleared.
module log_spread_rolling_zscore (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsz_in_if.sink    i_in,
    lsz_out_if.source o_out,
    lsz_cfg_if.sink   i_cfg
);
    import lsz_pkg::*;

    t_state r_state, n_state;

    logic [ASSETS_W-1:0]        r_assets;
    logic [WINLEN_W-1:0]        r_window;
    logic signed [HEDGE_W-1:0]  r_hedge [PRICE_INPUTS];

    logic [PRICE_W-1:0]         r_price [PRICE_INPUTS];
    logic [ASSET_W-1:0]         r_asset;
    logic [31:0]                r_m;
    logic [4:0]                 r_k;
    logic [2:0]                 r_nstep;
    logic [LG_W-1:0]            r_lg;
    logic [4:0]                 r_i;
    logic signed [31:0]         r_ln;
    logic                       r_wneg;
    logic signed [ACC_W-1:0]    r_acc;
    logic [63:0]                r_prod;

    logic signed [SPREAD_W-1:0] r_spread;
    logic [ADDR_W-1:0]          r_oldest;
    logic [CNT_W-1:0]           r_fill;
    logic [CNT_W-1:0]           r_idx;
    logic                       r_rv, r_mv, r_pv;
    logic [SPREAD_W-1:0]        r_rdata;
    logic [31:0]                r_mag;
    logic signed [SUM_W-1:0]    r_sum;
    logic [63:0]                r_sq;
    logic signed [SPREAD_W-1:0] r_mean;
    logic                       r_sneg;

    t_div_op                    r_dop;
    logic [63:0]                r_dn;
    logic [31:0]                r_dd;
    logic [31:0]                r_drem;
    logic [63:0]                r_dq;
    logic [6:0]                 r_dcnt;

    logic [63:0]                r_sv, r_sr;
    logic [4:0]                 r_sj;

    logic [SPREAD_W-1:0]        r_dev;
    logic signed [Z_W-1:0]      r_z;
    logic                       r_ok;

    logic                       r_ovalid;
    logic signed [SPREAD_W-1:0] r_o_spread, r_o_mean;
    logic [SPREAD_W-1:0]        r_o_dev;
    logic signed [Z_W-1:0]      r_o_z;
    logic                       r_o_ok;
    logic [ENTRIES_W-1:0]       r_o_n;

    logic [SPREAD_W-1:0]        mem [WINDOW_DEPTH];

    logic                       in_acc, out_acc, cfg_acc;
    logic [ASSETS_W-1:0]        na_c;
    logic [CNT_W-1:0]           wl_c;
    logic [31:0]                mul_a, mul_b;
    logic [5:0]                 norm_sh;
    logic                       top_zero;
    logic [4:0]                 k_new;
    logic                       last_asset;
    logic signed [HEDGE_W-1:0]  hedge_sel;
    logic [ADDR_W-1:0]          rd_addr, wr_addr;
    logic                       mem_we;
    logic                       pass_done, var_done;
    logic [32:0]                rem2;
    logic                       div_ge;
    logic [63:0]                sq_bit, sq_t;
    logic                       out_free;

    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W:0] a);
        logic [ADDR_W:0] s;
        s = (a >= (ADDR_W+1)'(WINDOW_DEPTH)) ? a - (ADDR_W+1)'(WINDOW_DEPTH) : a;
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic [31:0] clamp_tick(input logic [PRICE_W-1:0] p);
        return (p == '0) ? 32'd1 : p;
    endfunction

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = r_ovalid && o_out.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign out_free = !r_ovalid || o_out.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid            = r_ovalid;
    assign o_out.spread_now       = r_o_spread;
    assign o_out.spread_average   = r_o_mean;
    assign o_out.spread_deviation = r_o_dev;
    assign o_out.z_value          = r_o_z;
    assign o_out.z_ok             = r_o_ok;
    assign o_out.entries_held     = r_o_n;

    always_comb begin
        if (r_assets == '0) begin
            na_c = ASSETS_W'(1);
        end else if (int'(r_assets) > ASSET_CAP) begin
            na_c = ASSETS_W'(ASSET_CAP);
        end else begin
            na_c = r_assets;
        end
        if (int'(r_window) > WINDOW_DEPTH) begin
            wl_c = CNT_W'(WINDOW_DEPTH);
        end else if (r_window < WINLEN_W'(2)) begin
            wl_c = CNT_W'(2);
        end else begin
            wl_c = CNT_W'(r_window);
        end
    end

    assign last_asset = (int'(r_asset) + 1 >= int'(na_c));
    assign hedge_sel  = r_hedge[r_asset];

    assign norm_sh  = 6'd16 >> r_nstep;
    assign top_zero = ((r_m >> (6'd32 - norm_sh)) == 32'd0);
    assign k_new    = top_zero ? r_k - norm_sh[4:0] : r_k;

    always_comb begin
        unique case (r_state)
            ST_SQ_MUL: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            ST_SCALE_MUL: begin
                mul_a = 32'(r_lg);
                mul_b = LN2_Q32;
            end
            ST_W_MUL: begin
                mul_a = r_ln[31] ? 32'(-r_ln) : 32'(r_ln);
                mul_b = {16'd0, hedge_sel[HEDGE_W-1] ? 16'(-hedge_sel) : 16'(hedge_sel)};
            end
            ST_VAR: begin
                mul_a = r_mag;
                mul_b = r_mag;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rd_addr = wrap_addr((ADDR_W+1)'(r_oldest) + (ADDR_W+1)'(r_idx));
    assign wr_addr = wrap_addr((ADDR_W+1)'(r_oldest) + (ADDR_W+1)'(r_fill));
    assign mem_we  = (r_state == ST_PUSH);

    assign pass_done = (r_idx == r_fill) && !r_rv;
    assign var_done  = pass_done && !r_mv && !r_pv;

    assign rem2   = {r_drem, r_dn[63]};
    assign div_ge = (rem2 >= {1'b0, r_dd});

    assign sq_bit = 64'd1 << {r_sj, 1'b0};
    assign sq_t   = r_sr + sq_bit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (in_acc) n_state = ST_NORM;
            ST_NORM:      if (r_nstep == 3'd4) n_state = ST_SQ_MUL;
            ST_SQ_MUL:    n_state = ST_SQ_UPD;
            ST_SQ_UPD:    n_state = (r_i == 5'd0) ? ST_SCALE_MUL : ST_SQ_MUL;
            ST_SCALE_MUL: n_state = ST_SCALE_FIN;
            ST_SCALE_FIN: n_state = ST_W_MUL;
            ST_W_MUL:     n_state = ST_W_ACC;
            ST_W_ACC:     n_state = last_asset ? ST_SPREAD : ST_NORM;
            ST_SPREAD:    n_state = ST_PUSH;
            ST_PUSH:      n_state = ST_SUM;
            ST_SUM:       if (pass_done) n_state = ST_DIV;
            ST_DIV: begin
                if (r_dcnt == '0) begin
                    unique case (r_dop)
                        DOP_MEAN: n_state = (r_fill < CNT_W'(2)) ? ST_FINISH : ST_VAR;
                        DOP_VAR:  n_state = ST_SQRT;
                        DOP_Z:    n_state = ST_FINISH;
                        default:  n_state = ST_FINISH;
                    endcase
                end
            end
            ST_VAR:       if (var_done) n_state = ST_DIV;
            ST_SQRT:      if (r_sj == 5'd0) n_state = ST_ZPREP;
            ST_ZPREP:     n_state = (r_sr[31:0] == 32'd0) ? ST_FINISH : ST_DIV;
            ST_FINISH:    if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_spread;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assets   <= ASSETS_W'(2);
            r_window   <= WINLEN_W'(64);
            r_hedge[0] <= 16'sd4096;
            r_hedge[1] <= -16'sd4096;
            r_hedge[2] <= 16'sd0;
            r_hedge[3] <= 16'sd0;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                CFG_ASSETS:  r_assets   <= i_cfg.data[ASSETS_W-1:0];
                CFG_WINDOW:  r_window   <= i_cfg.data[WINLEN_W-1:0];
                CFG_HEDGE_A: r_hedge[0] <= i_cfg.data;
                CFG_HEDGE_B: r_hedge[1] <= i_cfg.data;
                CFG_HEDGE_C: r_hedge[2] <= i_cfg.data;
                CFG_HEDGE_D: r_hedge[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_fill   <= '0;
            r_rv     <= 1'b0;
            r_mv     <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_rv <= ((r_state == ST_SUM) || (r_state == ST_VAR)) && (r_idx < r_fill);
            r_mv <= (r_state == ST_VAR) && r_rv;
            r_pv <= (r_state == ST_VAR) && r_mv;
            if (r_state == ST_SPREAD && r_fill >= wl_c) begin
                r_oldest <= wrap_addr((ADDR_W+1)'(r_oldest)
                                      + (ADDR_W+1)'(r_fill - wl_c + CNT_W'(1)));
                r_fill   <= wl_c - CNT_W'(1);
            end else if (r_state == ST_PUSH) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            if (r_state == ST_FINISH && out_free) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [ACC_W-1:0]      amag;
        logic [ACC_W-1:0]      aq;
        logic [SUM_W-1:0]      smag;
        logic signed [32:0]    diff;
        logic [64:0]           ssum;
        logic [32:0]           sq33;
        logic [31:0]           zmag;
        logic [63:0]           q;
        logic signed [32:0]    mean33;

        r_prod <= 64'(mul_a) * 64'(mul_b);

        if (r_rv && r_state == ST_SUM) begin
            r_sum <= r_sum + SUM_W'($signed(r_rdata));
        end
        diff  = 33'($signed(r_rdata)) - 33'(r_mean);
        r_mag <= diff[32] ? 32'(-diff) : 32'(diff);
        if (r_pv) begin
            ssum = {1'b0, r_sq} + {1'b0, r_prod};
            r_sq <= ssum[64] ? '1 : ssum[63:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_price[0] <= i_in.price_a;
                    r_price[1] <= i_in.price_b;
                    r_price[2] <= i_in.price_c;
                    r_price[3] <= i_in.price_d;
                    r_m     <= clamp_tick(i_in.price_a);
                    r_k     <= 5'd31;
                    r_nstep <= '0;
                    r_asset <= '0;
                    r_acc   <= '0;
                end
            end
            ST_NORM: begin
                if (top_zero) begin
                    r_m <= r_m << norm_sh;
                end
                r_k     <= k_new;
                r_nstep <= r_nstep + 3'd1;
                r_lg    <= {k_new, LOG_FRAC'(0)};
                r_i     <= 5'(LOG_FRAC - 1);
            end
            ST_SQ_UPD: begin
                sq33 = r_prod[63:31];
                if (sq33[32]) begin
                    r_m       <= sq33[32:1];
                    r_lg[r_i] <= 1'b1;
                end else begin
                    r_m <= sq33[31:0];
                end
                r_i <= r_i - 5'd1;
            end
            ST_SCALE_FIN: begin
                r_ln <= $signed(32'((r_prod + (64'd1 << 35)) >> 36) - LN_TICK_Q16);
            end
            ST_W_MUL: begin
                r_wneg <= r_ln[31] ^ hedge_sel[HEDGE_W-1];
            end
            ST_W_ACC: begin
                r_acc <= r_wneg ? r_acc - $signed(ACC_W'(r_prod))
                                : r_acc + $signed(ACC_W'(r_prod));
                if (!last_asset) begin
                    r_asset <= r_asset + ASSET_W'(1);
                    r_m     <= clamp_tick(r_price[r_asset + ASSET_W'(1)]);
                    r_k     <= 5'd31;
                    r_nstep <= '0;
                end
            end
            ST_SPREAD: begin
                amag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
                aq   = (amag + ACC_W'(2048)) >> 12;
                r_spread <= r_acc[ACC_W-1] ? -$signed(32'(aq)) : $signed(32'(aq));
            end
            ST_PUSH: begin
                r_idx <= '0;
                r_sum <= '0;
            end
            ST_SUM: begin
                if (r_idx < r_fill) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (pass_done) begin
                    smag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                    r_sneg <= r_sum[SUM_W-1];
                    r_dn   <= (64'(smag) + 64'(r_fill >> 1)) << (64 - MEAN_DIV_BITS);
                    r_dd   <= 32'(r_fill);
                    r_drem <= '0;
                    r_dq   <= '0;
                    r_dcnt <= 7'(MEAN_DIV_BITS);
                    r_dop  <= DOP_MEAN;
                end
            end
            ST_DIV: begin
                if (r_dcnt != '0) begin
                    r_drem <= div_ge ? 32'(rem2 - {1'b0, r_dd}) : rem2[31:0];
                    r_dq   <= {r_dq[62:0], div_ge};
                    r_dn   <= r_dn << 1;
                    r_dcnt <= r_dcnt - 7'd1;
                end else begin
                    q = r_dq;
                    unique case (r_dop)
                        DOP_MEAN: begin
                            r_mean <= r_sneg ? -$signed(q[31:0]) : $signed(q[31:0]);
                            r_idx  <= '0;
                            r_sq   <= '0;
                            r_dev  <= '0;
                            r_z    <= '0;
                            r_ok   <= 1'b0;
                        end
                        DOP_VAR: begin
                            r_sv <= q;
                            r_sr <= '0;
                            r_sj <= 5'd31;
                        end
                        DOP_Z: begin
                            if (r_sneg) begin
                                r_z <= (q > 64'd32768) ? -16'sd32768 : $signed(16'(-q));
                            end else begin
                                r_z <= (q > 64'd32767) ? 16'sd32767 : $signed(q[15:0]);
                            end
                            r_ok <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_VAR: begin
                if (r_idx < r_fill) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (var_done) begin
                    r_dn   <= r_sq;
                    r_dd   <= 32'(r_fill - CNT_W'(1));
                    r_drem <= '0;
                    r_dq   <= '0;
                    r_dcnt <= 7'(VAR_DIV_BITS);
                    r_dop  <= DOP_VAR;
                end
            end
            ST_SQRT: begin
                if (r_sv >= sq_t) begin
                    r_sv <= r_sv - sq_t;
                    r_sr <= (r_sr >> 1) + sq_bit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sj <= r_sj - 5'd1;
            end
            ST_ZPREP: begin
                r_dev  <= r_sr[31:0];
                mean33 = 33'(r_mean);
                diff   = 33'(r_spread) - mean33;
                zmag   = diff[32] ? 32'(-diff) : 32'(diff);
                r_sneg <= diff[32];
                r_dn   <= ((64'(zmag) << 8) + 64'(r_sr[31:1])) << (64 - Z_DIV_BITS);
                r_dd   <= r_sr[31:0];
                r_drem <= '0;
                r_dq   <= '0;
                r_dcnt <= 7'(Z_DIV_BITS);
                r_dop  <= DOP_Z;
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_o_spread <= r_spread;
                    r_o_mean   <= r_mean;
                    r_o_dev    <= r_dev;
                    r_o_z      <= r_z;
                    r_o_ok     <= r_ok;
                    r_o_n      <= ENTRIES_W'(r_fill);
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/lsz_chk.sv =====
module lsz_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [lsz_pkg::SPREAD_W-1:0]        i_dev,
    input logic signed [lsz_pkg::Z_W-1:0]      i_z,
    input logic                                i_z_ok,
    input logic [lsz_pkg::ENTRIES_W-1:0]       i_entries
);
    import lsz_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in work");

    a_ok_needs_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_z_ok) |-> (i_entries >= ENTRIES_W'(2) && i_dev != '0))
        else $error("z flagged valid without two entries and nonzero deviation");

    a_single_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_entries <= ENTRIES_W'(1))
            |-> (i_dev == '0 && i_z == '0 && !i_z_ok && i_entries == ENTRIES_W'(1)))
        else $error("single entry result not cleared");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_dev) && $stable(i_z)))
        else $error("stalled result word changed");

endmodule

bind log_spread_rolling_zscore lsz_chk u_lsz_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_dev       (o_out.spread_deviation),
    .i_z         (o_out.z_value),
    .i_z_ok      (o_out.z_ok),
    .i_entries   (o_out.entries_held)
);
